// File: src/iprhc_pkg.sv
// Shared types and constants for the IPv4 receive header check.
// Used by iprhc_hdr_capture, iprhc_verdict and ipv4_receive_header_check_core.
`default_nettype none

package iprhc_pkg;

    localparam int unsigned HDR_BYTES = 20;
    localparam int unsigned IDX_W = 5;

    localparam logic [IDX_W-1:0] OFS_VER_IHL  = 5'd0;
    localparam logic [IDX_W-1:0] OFS_TLEN_HI  = 5'd2;
    localparam logic [IDX_W-1:0] OFS_TLEN_LO  = 5'd3;
    localparam logic [IDX_W-1:0] OFS_PROTO    = 5'd9;
    localparam logic [IDX_W-1:0] OFS_SRC_FIRST = 5'd12;
    localparam logic [IDX_W-1:0] OFS_SRC_LAST  = 5'd15;
    localparam logic [IDX_W-1:0] OFS_DST_FIRST = 5'd16;
    localparam logic [IDX_W-1:0] OFS_DST_LAST  = 5'd19;

    localparam logic [15:0] HDR_LEN16     = 16'd20;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
    localparam logic [7:0]  VER_IHL_IPV4  = 8'h45;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [31:0] ADDR_UNSET    = 32'h0000_0000;
    localparam logic [31:0] ADDR_BCAST    = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        VERDICT_ICMP      = 3'd0,
        VERDICT_UDP       = 3'd1,
        VERDICT_OTHER     = 3'd2,
        VERDICT_SHORT     = 3'd3,
        VERDICT_BAD_VER   = 3'd4,
        VERDICT_BAD_LEN   = 3'd5,
        VERDICT_NOT_OURS  = 3'd6,
        VERDICT_BAD_CSUM  = 3'd7
    } t_verdict;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] checksum;
        logic [7:0]  ver_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
    } t_hdr;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [15:0] payload_length;
        logic [31:0] source;
        t_verdict    verdict;
    } t_result;

endpackage

`default_nettype wire

// File: src/iprhc_hdr_capture.sv
// Per-byte header capture: byte counter, field captures and running checksum.
// Depends on iprhc_pkg; presents the packet state as it stands after the current byte.
`default_nettype none

module iprhc_hdr_capture (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data,
    input  wire logic           i_last,
    output iprhc_pkg::t_hdr     o_hdr
);

    iprhc_pkg::t_hdr r_hdr;
    iprhc_pkg::t_hdr n_hdr;
    logic [7:0] r_pending;
    logic [7:0] n_pending;

    logic                            in_hdr;
    logic [iprhc_pkg::IDX_W-1:0]     idx;
    logic [16:0]                     sum_raw;
    logic [15:0]                     sum_fold;

    always_comb begin
        in_hdr   = (r_hdr.byte_count < iprhc_pkg::HDR_LEN16);
        idx      = r_hdr.byte_count[iprhc_pkg::IDX_W-1:0];
        sum_raw  = {1'b0, r_hdr.checksum} + {1'b0, r_pending, i_data};
        sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};

        n_hdr     = r_hdr;
        n_pending = r_pending;

        if (in_hdr) begin
            if (idx == iprhc_pkg::OFS_VER_IHL) begin
                n_hdr.ver_ihl = i_data;
            end else if (idx == iprhc_pkg::OFS_TLEN_HI) begin
                n_hdr.total_length[15:8] = i_data;
            end else if (idx == iprhc_pkg::OFS_TLEN_LO) begin
                n_hdr.total_length[7:0] = i_data;
            end else if (idx == iprhc_pkg::OFS_PROTO) begin
                n_hdr.protocol = i_data;
            end else if (idx >= iprhc_pkg::OFS_SRC_FIRST && idx <= iprhc_pkg::OFS_SRC_LAST) begin
                n_hdr.source = {r_hdr.source[23:0], i_data};
            end else if (idx >= iprhc_pkg::OFS_DST_FIRST && idx <= iprhc_pkg::OFS_DST_LAST) begin
                n_hdr.destination = {r_hdr.destination[23:0], i_data};
            end

            if (idx[0] == 1'b0) begin
                n_pending = i_data;
            end else begin
                n_hdr.checksum = sum_fold;
            end
        end

        if (r_hdr.byte_count != iprhc_pkg::COUNT_MAX) begin
            n_hdr.byte_count = r_hdr.byte_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr     <= '0;
            r_pending <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_hdr     <= '0;
                r_pending <= '0;
            end else begin
                r_hdr     <= n_hdr;
                r_pending <= n_pending;
            end
        end
    end

    assign o_hdr = n_hdr;

endmodule

`default_nettype wire

// File: src/iprhc_verdict.sv
// Verdict logic: ordered header checks and protocol dispatch for one packet.
// Depends on iprhc_pkg; purely combinational, registered by the top level.
`default_nettype none

module iprhc_verdict (
    input  wire iprhc_pkg::t_hdr    i_hdr,
    input  wire logic [31:0]        i_local_address,
    output iprhc_pkg::t_result      o_result
);

    logic addr_ok;

    always_comb begin
        addr_ok = (i_hdr.destination == i_local_address) ||
                  (i_local_address == iprhc_pkg::ADDR_UNSET &&
                   i_hdr.destination == iprhc_pkg::ADDR_BCAST);

        o_result.source         = i_hdr.source;
        o_result.protocol       = i_hdr.protocol;
        o_result.payload_length = '0;

        if (i_hdr.byte_count < iprhc_pkg::HDR_LEN16) begin
            o_result.verdict = iprhc_pkg::VERDICT_SHORT;
        end else if (i_hdr.ver_ihl != iprhc_pkg::VER_IHL_IPV4) begin
            o_result.verdict = iprhc_pkg::VERDICT_BAD_VER;
        end else if (i_hdr.total_length < iprhc_pkg::HDR_LEN16 ||
                     i_hdr.total_length > i_hdr.byte_count) begin
            o_result.verdict = iprhc_pkg::VERDICT_BAD_LEN;
        end else if (!addr_ok) begin
            o_result.verdict = iprhc_pkg::VERDICT_NOT_OURS;
        end else if (i_hdr.checksum != iprhc_pkg::CSUM_GOOD) begin
            o_result.verdict = iprhc_pkg::VERDICT_BAD_CSUM;
        end else begin
            o_result.payload_length = i_hdr.total_length - iprhc_pkg::HDR_LEN16;
            if (i_hdr.protocol == iprhc_pkg::PROTO_ICMP) begin
                o_result.verdict = iprhc_pkg::VERDICT_ICMP;
            end else if (i_hdr.protocol == iprhc_pkg::PROTO_UDP) begin
                o_result.verdict = iprhc_pkg::VERDICT_UDP;
            end else begin
                o_result.verdict = iprhc_pkg::VERDICT_OTHER;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/ipv4_receive_header_check_core.sv
// Top level of the IPv4 receive header check: local address register and result register.
// Depends on iprhc_pkg, iprhc_hdr_capture and iprhc_verdict.
//
//  Channel   Direction  Payload                                   Transfer
//  s (bytes) in         tdata: data_byte, tlast: last_byte        tvalid & tready
//  m (result) out       tdata: source, payload length, protocol   tvalid & tready
//                       tuser: verdict
//  cfg       in         local address                             write enable
//
// A byte is taken each cycle ready is high; a packet's result shows the cycle after its last byte.
// The result is held in the single result register after the verdict logic.
// Input ready drops only while a result is held and the downstream side is not ready.
// Synchronous active-low reset clears the packet state, the result valid and the local address.
`default_nettype none

module ipv4_receive_header_check_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,    // [31:0] source, [47:32] payload length, [55:48] protocol
    output logic [2:0]       o_m_tuser,    // [2:0] verdict
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    logic [31:0]          r_local_address;
    logic                 r_out_valid;
    iprhc_pkg::t_result   r_out;
    iprhc_pkg::t_hdr      hdr_now;
    iprhc_pkg::t_result   n_out;
    logic                 s_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    iprhc_hdr_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_data   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_hdr    (hdr_now)
    );

    iprhc_verdict u_verdict (
        .i_hdr           (hdr_now),
        .i_local_address (r_local_address),
        .o_result        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (i_cfg_wr_en) begin
            r_local_address <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && i_s_tlast) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.protocol, r_out.payload_length, r_out.source};
    assign o_m_tuser  = r_out.verdict;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> o_m_tvalid)
        else $error("last byte accepted without a result");

    a_reject_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2] == 1'b1) |-> (o_m_tdata[47:32] == 16'd0))
        else $error("rejected packet carries a payload length");

    a_short_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == iprhc_pkg::VERDICT_SHORT) |-> (o_m_tdata[47:32] == 16'd0))
        else $error("short packet carries a payload length");

    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == iprhc_pkg::VERDICT_ICMP) |->
        (o_m_tdata[55:48] == iprhc_pkg::PROTO_ICMP))
        else $error("icmp verdict with another protocol");

endmodule

`default_nettype wire
